// ===== design/fpr_pkg.sv =====
// fpr_pkg: shared sizes and the control bundle of the fifo page replacement block
// holds frame count, page width, port widths and the cell control struct
// no dependencies
package fpr_pkg;

	// built frame count and stored page width
	localparam int MAX_FRAMES = 16;
	localparam int PAGE_BITS  = 16;

	// fixed port widths
	localparam int PAGE_IN_W = 16;
	localparam int CFG_W     = 5;
	localparam int OCC_W     = 5;
	localparam int CNT_W     = 32;

	// fill count holds 0..MAX_FRAMES
	localparam int FCNT_W = $clog2(MAX_FRAMES + 1);

	// broadcast from the top to every cell for one request
	typedef struct packed {
		logic                 append;
		logic                 evict;
		logic [PAGE_BITS-1:0] page;
	} fpr_cell_ctrl_t;

endpackage

// ===== design/fpr_cell.sv =====
// fpr_cell: one page frame of the replacement chain
// holds a page and its valid bit, compares against the request, shifts toward the oldest end
// depends on fpr_pkg
module fpr_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fpr_pkg::fpr_cell_ctrl_t       ctrl,
	input  logic                          prev_valid,
	input  logic                          next_valid,
	input  logic [fpr_pkg::PAGE_BITS-1:0] next_page,
	input  logic                          hit_in,
	output logic                          hit_out,
	output logic                          valid,
	output logic [fpr_pkg::PAGE_BITS-1:0] page
);
	import fpr_pkg::*;

	logic                 valid_q;
	logic [PAGE_BITS-1:0] page_q;
	logic                 take_new;

	// first empty frame takes the page on an append
	assign take_new = ctrl.append && !valid_q && prev_valid;

	// hit ripples along the chain
	assign hit_out = hit_in || (valid_q && (page_q == ctrl.page));

	// valid bit fills once and stays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end
	end

	// page load, or on an eviction shift one step older, the newest frame taking the request page
	always_ff @(posedge clk) begin
		if (take_new) begin
			page_q <= ctrl.page;
		end else if (ctrl.evict && valid_q) begin
			page_q <= next_valid ? next_page : ctrl.page;
		end
	end

	assign valid = valid_q;
	assign page  = page_q;

endmodule

// ===== design/fifo_page_replacement_top.sv =====
// fifo_page_replacement_top: fifo page replacement unit, top level
// a chain of fpr_cell frames plus fill count, counters and result register
// depends on fpr_pkg and fpr_cell
//
// usage
//   input channel: in_valid / in_ready with page_number, one page reference per request
//   output channel: out_valid / out_ready with was_hit, evict_valid, evicted_page,
//     occupancy, hit_total and fault_total, exactly one result per reference
//   config channel: cfg_valid / cfg_ready with num_frames; cfg_ready is always high,
//     write it only while no reference is in flight
//   result: registered; it shows in the cycle after the reference is accepted
//   throughput: one reference per cycle while no result is held; the lookup is a
//     compare in every frame cell with the hit rippling along the chain, and the
//     update shifts the chain in the same cycle
//   stall: a result held by a low out_ready keeps in_ready low until it is taken;
//     in_ready is high whenever the result register is empty or being emptied
//   reset: arst_n clears all frames, the fill count and both counters, and sets
//     num_frames to 16; no clearing pass is needed
//   num_frames of 0 acts as 1, above 16 acts as 16; lowering it leaves the
//     occupied frames in place until replaced
module fifo_page_replacement_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fpr_pkg::PAGE_IN_W-1:0] page_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          was_hit,
	output logic                          evict_valid,
	output logic [fpr_pkg::PAGE_IN_W-1:0] evicted_page,
	output logic [fpr_pkg::OCC_W-1:0]     occupancy,
	output logic [fpr_pkg::CNT_W-1:0]     hit_total,
	output logic [fpr_pkg::CNT_W-1:0]     fault_total,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fpr_pkg::CFG_W-1:0]     num_frames
);
	import fpr_pkg::*;

	logic [CFG_W-1:0]     num_frames_q;
	logic [FCNT_W-1:0]    fill_q;
	logic [FCNT_W-1:0]    limit;
	logic [CNT_W-1:0]     hit_cnt_q;
	logic [CNT_W-1:0]     fault_cnt_q;
	logic                 out_valid_q;
	logic                 hit_q;
	logic                 evict_q;
	logic [PAGE_BITS-1:0] victim_q;

	logic                 accept;
	logic                 hit;
	logic                 has_room;
	fpr_cell_ctrl_t       ctrl;

	logic                 vld_ext [0:MAX_FRAMES+1];
	logic [PAGE_BITS-1:0] pg_ext  [0:MAX_FRAMES];
	logic                 hit_chain [0:MAX_FRAMES];

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= CFG_W'(MAX_FRAMES);
		end else if (cfg_valid && cfg_ready) begin
			num_frames_q <= num_frames;
		end
	end

	// effective frame limit
	always_comb begin
		if (num_frames_q == '0) begin
			limit = FCNT_W'(1);
		end else if (int'(num_frames_q) > MAX_FRAMES) begin
			limit = FCNT_W'(MAX_FRAMES);
		end else begin
			limit = FCNT_W'(num_frames_q);
		end
	end

	// request handshake
	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// cell control
	assign has_room    = (fill_q < limit) && (int'(fill_q) < MAX_FRAMES);
	assign ctrl.page   = page_number[PAGE_BITS-1:0];
	assign ctrl.append = accept && !hit && has_room;
	assign ctrl.evict  = accept && !hit && !has_room && (fill_q != '0);

	// chain ends
	assign vld_ext[0]            = 1'b1;
	assign vld_ext[MAX_FRAMES+1] = 1'b0;
	assign pg_ext[MAX_FRAMES]    = '0;
	assign hit_chain[0]          = 1'b0;
	assign hit                   = hit_chain[MAX_FRAMES];

	// row of frame cells, oldest at index 0
	for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
		fpr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (vld_ext[i]),
			.next_valid (vld_ext[i+2]),
			.next_page  (pg_ext[i+1]),
			.hit_in     (hit_chain[i]),
			.hit_out    (hit_chain[i+1]),
			.valid      (vld_ext[i+1]),
			.page       (pg_ext[i])
		);
	end

	// fill count and saturating counters, updated only with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			hit_cnt_q   <= '0;
			fault_cnt_q <= '0;
		end else if (accept) begin
			if (ctrl.append) begin
				fill_q <= fill_q + FCNT_W'(1);
			end
			if (hit) begin
				if (hit_cnt_q != '1) begin
					hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end
			end else if (fault_cnt_q != '1) begin
				fault_cnt_q <= fault_cnt_q + CNT_W'(1);
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q    <= hit;
			evict_q  <= ctrl.evict;
			victim_q <= ctrl.evict ? pg_ext[0] : '0;
		end
	end

	// counters and fill only move when a new result loads, so they read out directly
	assign out_valid    = out_valid_q;
	assign was_hit      = hit_q;
	assign evict_valid  = evict_q;
	assign evicted_page = PAGE_IN_W'(victim_q);
	assign occupancy    = OCC_W'(fill_q);
	assign hit_total    = hit_cnt_q;
	assign fault_total  = fault_cnt_q;

endmodule

// ===== design/fpr_checker.sv =====
// fpr_checker: port level checks for fifo_page_replacement_top
// bound to the top level; sees its ports only
// depends on fpr_pkg
module fpr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic [fpr_pkg::PAGE_IN_W-1:0] page_number,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          was_hit,
	input logic                          evict_valid,
	input logic [fpr_pkg::PAGE_IN_W-1:0] evicted_page,
	input logic [fpr_pkg::OCC_W-1:0]     occupancy,
	input logic [fpr_pkg::CNT_W-1:0]     hit_total,
	input logic [fpr_pkg::CNT_W-1:0]     fault_total,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [fpr_pkg::CFG_W-1:0]     num_frames
);
	import fpr_pkg::*;

	// every accepted request yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted request");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(was_hit) && $stable(evicted_page)
			&& $stable(hit_total) && $stable(fault_total))
		else $error("stalled result changed");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(was_hit && evict_valid))
		else $error("hit reported with eviction");

	// no eviction means a zero evicted page, and an eviction comes with a nonzero occupancy
	a_evict_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (evict_valid ? (occupancy != '0) : (evicted_page == '0)))
		else $error("eviction fields inconsistent");

endmodule

bind fifo_page_replacement_top fpr_checker u_fpr_checker (.*);

// ===== tb/sv/fifo_page_replacement_checker.sv =====
`timescale 1ns / 1ps
// fifo_page_replacement_checker: watches the request, result and config channels of the
// page replacement unit, predicts every result and compares it field by field
// depends on fpr_pkg
module fifo_page_replacement_checker
	import fpr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PAGE_IN_W-1:0] page_number,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 was_hit,
	input  logic                 evict_valid,
	input  logic [PAGE_IN_W-1:0] evicted_page,
	input  logic [OCC_W-1:0]     occupancy,
	input  logic [CNT_W-1:0]     hit_total,
	input  logic [CNT_W-1:0]     fault_total,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_W-1:0]     num_frames,
	output int                   fail_count,
	output int                   pending_lookups
);

	typedef struct packed {
		logic                 hit;
		logic                 evict;
		logic [PAGE_IN_W-1:0] victim;
		logic [OCC_W-1:0]     occ;
		logic [CNT_W-1:0]     hits;
		logic [CNT_W-1:0]     faults;
	} lookup_result_t;

	// shadow copy of the frame chain, oldest page at index 0
	logic [PAGE_BITS-1:0] shadow_pages [MAX_FRAMES];
	int                   shadow_fill;
	logic [CNT_W-1:0]     shadow_hits;
	logic [CNT_W-1:0]     shadow_faults;
	logic [CFG_W-1:0]     shadow_frames_cfg;

	lookup_result_t predicted_lookups [$];
	lookup_result_t want;

	task automatic flag_error(input string msg);
		$display("[%0t] checker: %s", $time, msg);
		fail_count++;
	endtask

	// one page reference through the shadow chain
	function automatic lookup_result_t predict_reference(input logic [PAGE_IN_W-1:0] page_in);
		lookup_result_t       r;
		logic [PAGE_BITS-1:0] page;
		int                   limit;
		logic                 hit;
		page = page_in[PAGE_BITS-1:0];
		// zero acts as one frame, anything above the built count as the built count
		if (shadow_frames_cfg == 0)
			limit = 1;
		else if (shadow_frames_cfg > MAX_FRAMES)
			limit = MAX_FRAMES;
		else
			limit = shadow_frames_cfg;
		hit = 1'b0;
		for (int i = 0; i < shadow_fill; i++)
			if (shadow_pages[i] == page)
				hit = 1'b1;
		r = '0;
		r.hit = hit;
		if (hit) begin
			if (shadow_hits != '1)
				shadow_hits++;
		end else begin
			if (shadow_faults != '1)
				shadow_faults++;
			// append while below the limit, otherwise evict the oldest page;
			// frames above a lowered limit stay until replaced
			if (shadow_fill < limit && shadow_fill < MAX_FRAMES) begin
				shadow_pages[shadow_fill] = page;
				shadow_fill++;
			end else if (shadow_fill > 0) begin
				r.evict = 1'b1;
				r.victim[PAGE_BITS-1:0] = shadow_pages[0];
				for (int i = 1; i < shadow_fill; i++)
					shadow_pages[i-1] = shadow_pages[i];
				shadow_pages[shadow_fill-1] = page;
			end
		end
		r.occ = shadow_fill[OCC_W-1:0];
		r.hits = shadow_hits;
		r.faults = shadow_faults;
		return r;
	endfunction

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_FRAMES; i++)
				shadow_pages[i] = '0;
			shadow_fill = 0;
			shadow_hits = '0;
			shadow_faults = '0;
			shadow_frames_cfg = CFG_W'(16);
			predicted_lookups.delete();
			fail_count = 0;
			pending_lookups = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				shadow_frames_cfg = num_frames;
			if (in_valid && in_ready)
				predicted_lookups.push_back(predict_reference(page_number));
			// compare the result against the oldest prediction
			if (out_valid && out_ready) begin
				if (predicted_lookups.size() == 0) begin
					flag_error("result with no request outstanding");
				end else begin
					want = predicted_lookups.pop_front();
					if (was_hit !== want.hit)
						flag_error($sformatf("was_hit got %0b want %0b", was_hit, want.hit));
					if (evict_valid !== want.evict)
						flag_error($sformatf("evict_valid got %0b want %0b",
							evict_valid, want.evict));
					if (evicted_page !== want.victim)
						flag_error($sformatf("evicted_page got %h want %h",
							evicted_page, want.victim));
					if (occupancy !== want.occ)
						flag_error($sformatf("occupancy got %0d want %0d", occupancy, want.occ));
					if (hit_total !== want.hits)
						flag_error($sformatf("hit_total got %0d want %0d", hit_total, want.hits));
					if (fault_total !== want.faults)
						flag_error($sformatf("fault_total got %0d want %0d",
							fault_total, want.faults));
				end
			end
			pending_lookups = predicted_lookups.size();
		end
	end

endmodule

// ===== tb/sv/fifo_page_replacement_top_tb.sv =====
`timescale 1ns / 1ps
// fifo_page_replacement_top_tb: drives page references and frame count writes into the
// page replacement unit with random gaps and stalls; verdict from the checker's count
// depends on fpr_pkg, fifo_page_replacement_top and fifo_page_replacement_checker
module fifo_page_replacement_top_tb;
	import fpr_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [PAGE_IN_W-1:0] page_number;
	logic                 out_valid;
	logic                 out_ready;
	logic                 was_hit;
	logic                 evict_valid;
	logic [PAGE_IN_W-1:0] evicted_page;
	logic [OCC_W-1:0]     occupancy;
	logic [CNT_W-1:0]     hit_total;
	logic [CNT_W-1:0]     fault_total;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     num_frames;

	int fail_count;
	int pending_lookups;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int wd_cycles = 0;

	// current working set of pages, so that hits and misses mix
	logic [PAGE_IN_W-1:0] ws_base = '0;
	int                   ws_size = 8;

	always #5 clk = ~clk;

	fifo_page_replacement_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.page_number  (page_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_hit      (was_hit),
		.evict_valid  (evict_valid),
		.evicted_page (evicted_page),
		.occupancy    (occupancy),
		.hit_total    (hit_total),
		.fault_total  (fault_total),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.num_frames   (num_frames)
	);

	fifo_page_replacement_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.page_number     (page_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.was_hit         (was_hit),
		.evict_valid     (evict_valid),
		.evicted_page    (evicted_page),
		.occupancy       (occupancy),
		.hit_total       (hit_total),
		.fault_total     (fault_total),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.num_frames      (num_frames),
		.fail_count      (fail_count),
		.pending_lookups (pending_lookups)
	);

	// result side: random stalls, decided at every falling edge
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// watchdog
	initial begin
		while (wd_cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			wd_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// present one request and hold it until taken; returns at a falling edge
	task automatic send_page(input logic [PAGE_IN_W-1:0] page);
		in_valid <= 1'b1;
		page_number <= page;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// random gap between requests, with junk on the idle payload
	task automatic sender_gap();
		int n;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			n = $urandom_range(1, 4);
			in_valid <= 1'b0;
			page_number <= PAGE_IN_W'($urandom);
			repeat (n) @(negedge clk);
		end
	endtask

	// wait until every predicted result has come back
	task automatic drain();
		while (pending_lookups != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_frames(input logic [CFG_W-1:0] value);
		cfg_valid <= 1'b1;
		num_frames <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly pages from the working set, sometimes any page, now and then a new set
	function automatic logic [PAGE_IN_W-1:0] next_page();
		if ($urandom_range(0, 99) < 3) begin
			ws_base = PAGE_IN_W'($urandom);
			ws_size = $urandom_range(2, 24);
		end
		if ($urandom_range(0, 99) < 75)
			return ws_base + PAGE_IN_W'($urandom_range(0, ws_size - 1));
		return PAGE_IN_W'($urandom);
	endfunction

	// idle the block, set the frame count, then a run of random references
	task automatic run_segment(input logic [CFG_W-1:0] frames, input int count);
		in_valid <= 1'b0;
		drain();
		write_frames(frames);
		for (int i = 0; i < count; i++) begin
			send_page(next_page());
			if (i == count / 2) begin
				// hold off until the block has answered everything
				in_valid <= 1'b0;
				drain();
			end else begin
				sender_gap();
			end
		end
	endtask

	// reset, directed references, random phases, verdict
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		page_number = '0;
		cfg_valid = 1'b0;
		num_frames = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// frame count zero behaves as a single frame
		write_frames(CFG_W'(0));
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'h0000);
		// small limit: fill, then evict the oldest
		in_valid <= 1'b0;
		drain();
		write_frames(CFG_W'(3));
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'h1234);
		send_page(16'h5555);
		// all-ones frame count clamps to the built maximum
		in_valid <= 1'b0;
		drain();
		write_frames(CFG_W'(31));
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'h8000);
		send_page(16'h7FFF);
		send_page(16'h0001);
		send_page(16'hAAAA);

		// sender idles less than the receiver stalls
		send_idle_pct = 31;
		recv_stall_pct = 53;
		run_segment(CFG_W'(5), 100);
		run_segment(CFG_W'(12), 150);

		// the other way round; count lowered while full, then above the maximum
		send_idle_pct = 53;
		recv_stall_pct = 31;
		run_segment(CFG_W'(16), 200);
		run_segment(CFG_W'(1), 150);
		run_segment(CFG_W'(20), 150);

		// back to back
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_segment(CFG_W'(0), 150);
		run_segment(CFG_W'(16), 300);

		in_valid <= 1'b0;
		drain();
		repeat (10) @(negedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fpr_pkg.sv
design/fpr_cell.sv
design/fifo_page_replacement_top.sv
design/fpr_checker.sv
tb/sv/fifo_page_replacement_checker.sv
tb/sv/fifo_page_replacement_top_tb.sv
